// ----- hdl/hrm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package hrm_pkg;
    localparam logic [63:0] RATE_ONE = 64'd1000000000;
    localparam int IVAL_W = 48;
    localparam int SUM_W = 54;
    localparam int RATE_W = 30;
    localparam logic CFG_WINDOW_LENGTH = 1'b0;
    localparam logic CFG_LOG_DEPTH = 1'b1;

    typedef struct packed {
        logic [63:0] time_ns;
        logic [31:0] beat_tag;
    } t_beat;

    typedef struct packed {
        logic [31:0] beat_number;
        logic [31:0] record_tag;
        logic [63:0] record_time;
        logic [9:0]  log_slot;
        logic [29:0] windowed_bps;
        logic [29:0] overall_bps;
        logic [29:0] latest_bps;
    } t_record;

    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;
endpackage
`default_nettype wire

// ----- hdl/hrm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface hrm_beat_if;
    import hrm_pkg::*;
    logic  valid;
    logic  ready;
    t_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface hrm_record_if;
    import hrm_pkg::*;
    logic    valid;
    logic    ready;
    t_record payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- hdl/heartbeat_rate_monitor_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// heartbeat rate monitor: one record per beat transaction. the first beat after
// reset stores the start time and reports zero rates. each later beat pushes its
// interval (saturated to 48 bits) into a ring of window_length entries kept with
// an exact running sum, then one shared restoring divider computes the windowed,
// global and instant rates in turn, each rounded half up and capped at 1e9.
// input ready is low while a beat is in work or its record waits. the record
// register frees once the record is taken. writing window_length empties the
// window; writing log_depth wraps the slot to zero if it lies at or beyond the
// new depth.
module heartbeat_rate_monitor_unit
    import hrm_pkg::*;
#(
    parameter int WINDOW_MAX = 64,
    parameter int LOG_MAX    = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    hrm_beat_if.sink         s_beat,
    hrm_record_if.source     m_record,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [10:0] i_cfg_data
);
    localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LW = (LOG_MAX > 1) ? $clog2(LOG_MAX) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_UPD  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  r_state;
    logic [1:0]  r_phase;
    logic [6:0]  r_wlen_reg;
    logic [10:0] r_depth_reg;
    logic        r_started;
    logic [63:0] r_first_time, r_prev_time;
    logic [31:0] r_beat_count;
    logic [SUM_W-1:0] r_sum;
    logic [PW-1:0] r_ptr;
    logic        r_full;
    logic [LW-1:0] r_slot;
    logic [IVAL_W-1:0] r_ring [WINDOW_MAX];
    logic [IVAL_W-1:0] r_old;
    logic [63:0] r_iv;
    logic [63:0] r_elapsed;
    logic [31:0] r_n;
    t_beat       r_beat;
    t_record     r_rec;
    logic        r_out_valid;
    logic [63:0] w_num, w_den;
    t_div_ctl    w_div_in, w_div_out;
    logic [RATE_W-1:0] w_rate;

    // effective register values
    logic [PW:0] w_wlen;
    logic [LW:0] w_depth;
    always_comb begin
        if (r_wlen_reg == 7'd0) w_wlen = (PW+1)'(1);
        else if (32'(r_wlen_reg) > WINDOW_MAX) w_wlen = (PW+1)'(WINDOW_MAX);
        else w_wlen = (PW+1)'(r_wlen_reg);
        if (r_depth_reg == 11'd0) w_depth = (LW+1)'(1);
        else if (32'(r_depth_reg) > LOG_MAX) w_depth = (LW+1)'(LOG_MAX);
        else w_depth = (LW+1)'(r_depth_reg);
    end

    logic [IVAL_W-1:0] w_sv;
    assign w_sv = (r_iv[63:IVAL_W] != '0) ? {IVAL_W{1'b1}} : r_iv[IVAL_W-1:0];

    logic [PW:0] w_ptr_inc;
    assign w_ptr_inc = {1'b0, r_ptr} + (PW+1)'(1);

    logic [LW:0] w_slot_inc;
    assign w_slot_inc = {1'b0, r_slot} + (LW+1)'(1);

    assign s_beat.ready    = (r_state == ST_IDLE) && !r_out_valid;
    assign m_record.valid  = r_out_valid;
    assign m_record.payload = r_rec;

    assign w_div_in.start = (r_state == ST_DIV);
    assign w_div_in.done  = 1'b0;

    hrm_rate_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_div_in),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_ctl  (w_div_out),
        .o_rate (w_rate)
    );

    // ring memory: one write port, one registered read
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) r_old <= r_ring[r_ptr];
        if (r_state == ST_UPD) r_ring[r_ptr] <= w_sv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= 2'd0;
            r_wlen_reg   <= 7'd20;
            r_depth_reg  <= 11'd1024;
            r_started    <= 1'b0;
            r_first_time <= '0;
            r_prev_time  <= '0;
            r_beat_count <= '0;
            r_sum        <= '0;
            r_ptr        <= '0;
            r_full       <= 1'b0;
            r_slot       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (m_record.valid && m_record.ready) r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WINDOW_LENGTH: begin
                        r_wlen_reg <= i_cfg_data[6:0];
                        r_ptr  <= '0;
                        r_full <= 1'b0;
                        r_sum  <= '0;
                    end
                    CFG_LOG_DEPTH: begin
                        r_depth_reg <= i_cfg_data;
                    end
                    default: ;
                endcase
            end
            if (i_cfg_we && i_cfg_index == CFG_LOG_DEPTH) begin
                // compare against the new depth
                if (i_cfg_data == 11'd0) begin
                    r_slot <= '0;
                end else if (32'(i_cfg_data) <= LOG_MAX &&
                             {1'b0, r_slot} >= (LW+1)'(i_cfg_data)) begin
                    r_slot <= '0;
                end
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_beat.valid && s_beat.ready) begin
                        r_beat    <= s_beat.payload;
                        r_iv      <= s_beat.payload.time_ns - r_prev_time;
                        r_elapsed <= s_beat.payload.time_ns - r_first_time;
                        r_rec.beat_number <= r_beat_count;
                        r_rec.record_tag  <= s_beat.payload.beat_tag;
                        r_rec.record_time <= s_beat.payload.time_ns;
                        r_rec.log_slot    <= 10'(r_slot);
                        r_rec.windowed_bps <= '0;
                        r_rec.overall_bps  <= '0;
                        r_rec.latest_bps   <= '0;
                        if (r_started) begin
                            r_state <= ST_READ;
                        end else begin
                            r_started    <= 1'b1;
                            r_first_time <= s_beat.payload.time_ns;
                            r_state      <= ST_OUT;
                        end
                    end
                end
                ST_READ: r_state <= ST_UPD;
                ST_UPD: begin
                    if (!r_full) begin
                        r_sum <= r_sum + SUM_W'(w_sv);
                        r_n   <= 32'(w_ptr_inc);
                        if (w_ptr_inc >= w_wlen) begin
                            r_ptr  <= '0;
                            r_full <= 1'b1;
                        end else begin
                            r_ptr <= w_ptr_inc[PW-1:0];
                        end
                    end else begin
                        r_sum <= r_sum - SUM_W'(r_old) + SUM_W'(w_sv);
                        r_n   <= 32'(w_wlen);
                        if (w_ptr_inc >= w_wlen) r_ptr <= '0;
                        else r_ptr <= w_ptr_inc[PW-1:0];
                    end
                    r_phase <= 2'd0;
                    r_state <= ST_DIV;
                end
                ST_DIV: r_state <= ST_WAIT;
                ST_WAIT: begin
                    if (w_div_out.done) begin
                        case (r_phase)
                            2'd0: r_rec.windowed_bps <= w_rate;
                            2'd1: r_rec.overall_bps <= w_rate;
                            default: r_rec.latest_bps <= w_rate;
                        endcase
                        if (r_phase == 2'd2) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_phase <= r_phase + 2'd1;
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_OUT: begin
                    r_prev_time  <= r_beat.time_ns;
                    r_beat_count <= r_beat_count + 32'd1;
                    if (w_slot_inc >= w_depth) r_slot <= '0;
                    else r_slot <= w_slot_inc[LW-1:0];
                    r_out_valid <= 1'b1;
                    r_state     <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // divider operands for the current phase, sampled by the divider on start
    always_comb begin
        case (r_phase)
            2'd0: begin
                w_num = RATE_ONE * {32'd0, r_n};
                w_den = {{(64-SUM_W){1'b0}}, r_sum};
            end
            2'd1: begin
                w_num = RATE_ONE * ({32'd0, r_beat_count} + 64'd1);
                w_den = r_elapsed;
            end
            default: begin
                w_num = RATE_ONE;
                w_den = r_iv;
            end
        endcase
    end

    // busy work never overlaps a waiting record
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_beat.ready |-> (r_state == ST_IDLE && !r_out_valid))
        else $error("ready outside idle");
    a_out_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_OUT)
        else $error("record raised outside output step");
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("bad divide phase");
endmodule
`default_nettype wire

// ----- hdl/hrm_rate_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle, then round half up and saturate
module hrm_rate_div
    import hrm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_div_ctl          i_ctl,
    input  wire logic [63:0]       i_num,
    input  wire logic [63:0]       i_den,
    output t_div_ctl               o_ctl,
    output logic [RATE_W-1:0]      o_rate
);
    logic [63:0] r_q, n_q;
    logic [64:0] r_rem, n_rem;
    logic [63:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, r_done;
    logic [64:0] w_shift;
    logic [64:0] w_twice;
    logic [63:0] w_qr;

    always_comb begin
        w_shift = {r_rem[63:0], r_q[63]};
        n_rem = r_rem;
        n_q = r_q;
        n_cnt = r_cnt;
        if (r_busy) begin
            n_q = {r_q[62:0], 1'b0};
            if (w_shift >= {1'b0, r_den}) begin
                n_rem = w_shift - {1'b0, r_den};
                n_q[0] = 1'b1;
            end else begin
                n_rem = w_shift;
            end
            n_cnt = r_cnt - 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                r_cnt <= n_cnt;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    // round half up: 2*rem >= den
    assign w_twice = {r_rem[63:0], 1'b0};
    always_comb begin
        w_qr = r_q + {63'd0, (w_twice >= {1'b0, r_den})};
        if (r_den == 64'd0 || w_qr > RATE_ONE) o_rate = RATE_ONE[RATE_W-1:0];
        else o_rate = w_qr[RATE_W-1:0];
    end

    assign o_ctl.start = 1'b0;
    assign o_ctl.done  = r_done;
endmodule
`default_nettype wire
